// ===== hdl/tde_pkg.sv =====
package tde_pkg;

	localparam int MAX_LENGTH   = 64;
	localparam int MAX_CHANNELS = 16;

	localparam int IDX_W  = $clog2(MAX_LENGTH);
	localparam int CH_W   = $clog2(MAX_CHANNELS);
	localparam int ROW_W  = 7;
	localparam int CHN_W  = 5;
	localparam int CFG_W  = 7;
	localparam int SMP_W  = 16;
	localparam int COEF_W = 32;
	localparam int PROD_W = SMP_W + COEF_W;
	// products summed over the record plus the shifted response sample
	localparam int ACC_W  = PROD_W + IDX_W + 2;
	// quotient magnitude bits examined before saturation
	localparam int QB     = COEF_W + 1;

	localparam logic CFG_ROW_LENGTH    = 1'b0;
	localparam logic CFG_CHANNEL_COUNT = 1'b1;

	typedef struct packed {
		logic rotate;
		logic shift_in;
	} cell_ctl_t;

endpackage

// ===== hdl/tde_cell.sv =====
module tde_cell (
	input  logic                         clk,
	input  tde_pkg::cell_ctl_t           ctl,
	input  logic                         wr_g,
	input  logic signed [tde_pkg::SMP_W-1:0]  u_prev,
	input  logic signed [tde_pkg::SMP_W-1:0]  u_next,
	input  logic signed [tde_pkg::COEF_W-1:0] g_next,
	input  logic signed [tde_pkg::COEF_W-1:0] g_wr_data,
	output logic signed [tde_pkg::SMP_W-1:0]  u_q,
	output logic signed [tde_pkg::COEF_W-1:0] g_q
);
	import tde_pkg::*;

	// one excitation sample and one coefficient, moving round the ring
	always_ff @(posedge clk) begin
		if (ctl.rotate) begin
			u_q <= u_next;
			g_q <= g_next;
		end else begin
			if (ctl.shift_in) begin
				u_q <= u_prev;
			end
			if (wr_g) begin
				g_q <= g_wr_data;
			end
		end
	end
endmodule

// ===== hdl/tde_div.sv =====
module tde_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tde_pkg::ACC_W-1:0]     num_mag,
	input  logic [tde_pkg::SMP_W-1:0]     den_mag,
	output logic                          done,
	output logic                          big,
	output logic [tde_pkg::QB-1:0]        quo
);
	import tde_pkg::*;

	localparam int CNT_W = $clog2(QB);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QB - 1);

	logic [ACC_W-1:0] rem_q;
	logic [ACC_W-1:0] dsh_q;
	logic [QB-1:0]    quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             big_q;
	logic [ACC_W-1:0] den_ext;

	assign den_ext = ACC_W'(den_mag);

	// restoring division, one quotient bit a cycle from the top
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num_mag;
			dsh_q <= den_ext << (QB - 1);
			quo_q <= '0;
			big_q <= (num_mag >= (den_ext << QB));
		end else if (busy_q) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[QB-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[QB-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign big  = big_q;
	assign quo  = quo_q;
endmodule

// ===== hdl/toeplitz_triangular_deconvolution_top.sv =====
// impulse response estimator: each input beat carries one excitation sample u_i and one
// response sample y_i (both signed q1.15) and yields one output beat with
// g_i = (y_i - sum over j<i of u_(i-j)*g_j) / u_0 in signed q16.16, saturated, tagged with
// its position and channel. once a beat is taken, the excitation samples and coefficients
// sit in a ring of 64 cells that rotates once round per item past a single 16x32
// multiply-accumulate, then a state drains the multiplier and another sets up the
// divider, then a restoring divider works out 33 quotient bits one per cycle and hands
// them over, and a final state writes the coefficient back. with a zero divisor the
// divider is skipped. the input side is ready only between items; a finished result waits
// in the output register and does not hold up the next input beat, but a result that
// finds the output register still full waits until it is taken.
module toeplitz_triangular_deconvolution_top (
	input  logic                       clk,
	input  logic                       arst_n,
	// u_i [15:0], y_i [31:16]
	input  logic [31:0]                s_tdata,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// impulse_value [31:0], sample_index [37:32], channel_index [41:38], zeros above
	output logic [47:0]                m_tdata,
	// saturated [0], divide_by_zero [1]
	output logic [1:0]                 m_tuser,
	output logic                       m_tlast,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic                       cfg_wr_en,
	input  logic                       cfg_index,
	input  logic [tde_pkg::CFG_W-1:0]  cfg_wdata
);
	import tde_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_SUM,
		S_PREP,
		S_DIV,
		S_FIN
	} state_t;

	state_t state_q;

	// configuration
	logic [ROW_W-1:0] row_length_q;
	logic [CHN_W-1:0] channel_count_q;
	logic [ROW_W-1:0] len_eff;
	logic [CHN_W-1:0] chans_eff;

	// record position and current item
	logic [IDX_W-1:0]        pos_q;
	logic [CH_W-1:0]         chan_q;
	logic [IDX_W-1:0]        cnt_q;
	logic signed [SMP_W-1:0] u0_q;
	logic signed [SMP_W-1:0] y_q;
	logic signed [SMP_W-1:0] in_u;
	logic                    accept;

	// multiply-accumulate at the head of the ring
	logic signed [PROD_W-1:0] prod_s1;
	logic                     prod_vld_s1;
	logic signed [ACC_W-1:0]  acc_q;

	// division
	logic signed [ACC_W-1:0] num;
	logic                    num_neg_q;
	logic                    dz_q;
	logic [ACC_W-1:0]        num_mag;
	logic [SMP_W-1:0]        den_mag;
	logic                    div_start;
	logic                    div_done;
	logic                    div_big;
	logic [QB-1:0]           div_quo;

	// result
	logic signed [COEF_W-1:0] g_res;
	logic                     sat_res;
	logic                     last_res;
	logic                     out_free;
	logic                     finish;

	// ring of cells
	cell_ctl_t                cell_ctl;
	logic signed [SMP_W-1:0]  cell_u [MAX_LENGTH];
	logic signed [COEF_W-1:0] cell_g [MAX_LENGTH];

	assign in_u     = s_tdata[SMP_W-1:0];
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;
	assign finish   = (state_q == S_FIN) && out_free;

	// out-of-range register values are clamped into the supported span
	always_comb begin
		if (row_length_q == '0) begin
			len_eff = ROW_W'(1);
		end else if (row_length_q > ROW_W'(MAX_LENGTH)) begin
			len_eff = ROW_W'(MAX_LENGTH);
		end else begin
			len_eff = row_length_q;
		end
		if (channel_count_q == '0) begin
			chans_eff = CHN_W'(1);
		end else if (channel_count_q > CHN_W'(MAX_CHANNELS)) begin
			chans_eff = CHN_W'(MAX_CHANNELS);
		end else begin
			chans_eff = channel_count_q;
		end
	end

	// a new sample enters cell 0 and pushes the older ones along, so that
	// cell j holds u_(i-j) and pairs with the coefficient g_j in the same cell
	assign cell_ctl.rotate   = (state_q == S_WALK);
	assign cell_ctl.shift_in = accept;

	for (genvar k = 0; k < MAX_LENGTH; k++) begin : g_ring
		localparam int NXT = (k + 1) % MAX_LENGTH;
		localparam int PRV = (k + MAX_LENGTH - 1) % MAX_LENGTH;
		logic signed [SMP_W-1:0] u_prev;

		if (k == 0) begin : g_head
			assign u_prev = in_u;
		end else begin : g_body
			assign u_prev = cell_u[PRV];
		end

		tde_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl),
			.wr_g      (finish && (pos_q == IDX_W'(k))),
			.u_prev    (u_prev),
			.u_next    (cell_u[NXT]),
			.g_next    (cell_g[NXT]),
			.g_wr_data (g_res),
			.u_q       (cell_u[k]),
			.g_q       (cell_g[k])
		);
	end

	// numerator is exact: y shifted into q.31 less the accumulated products
	assign num       = $signed({{(ACC_W-SMP_W-16){y_q[SMP_W-1]}}, y_q, 16'b0}) - acc_q;
	assign num_mag   = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
	assign den_mag   = u0_q[SMP_W-1] ? SMP_W'(-u0_q) : SMP_W'(u0_q);
	assign div_start = (state_q == S_PREP) && (u0_q != '0);

	tde_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num_mag (num_mag),
		.den_mag (den_mag),
		.done    (div_done),
		.big     (div_big),
		.quo     (div_quo)
	);

	// sign, truncation toward zero and saturation of the quotient
	always_comb begin
		g_res   = '0;
		sat_res = 1'b0;
		if (!dz_q) begin
			if (num_neg_q ^ u0_q[SMP_W-1]) begin
				if (div_big || (div_quo > QB'(33'h0_8000_0000))) begin
					g_res   = {1'b1, {(COEF_W-1){1'b0}}};
					sat_res = 1'b1;
				end else begin
					g_res = -$signed(div_quo[COEF_W-1:0]);
				end
			end else begin
				if (div_big || (div_quo > QB'(33'h0_7fff_ffff))) begin
					g_res   = {1'b0, {(COEF_W-1){1'b1}}};
					sat_res = 1'b1;
				end else begin
					g_res = $signed(div_quo[COEF_W-1:0]);
				end
			end
		end
	end

	assign last_res = ((ROW_W'(pos_q) + ROW_W'(1)) >= len_eff);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q    <= ROW_W'(64);
			channel_count_q <= CHN_W'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_ROW_LENGTH:    row_length_q    <= cfg_wdata[ROW_W-1:0];
				CFG_CHANNEL_COUNT: channel_count_q <= cfg_wdata[CHN_W-1:0];
				default:           ;
			endcase
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= '0;
			chan_q      <= '0;
			cnt_q       <= '0;
			prod_vld_s1 <= 1'b0;
			m_tvalid    <= 1'b0;
		end else begin
			if (finish) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			// cell 0 shows pair j = cnt_q before this rotation
			prod_vld_s1 <= (state_q == S_WALK) && (cnt_q < pos_q);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q   <= '0;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == IDX_W'(MAX_LENGTH - 1)) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					state_q <= S_PREP;
				end
				S_PREP: begin
					state_q <= (u0_q == '0) ? S_FIN : S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (last_res) begin
							pos_q  <= '0;
							chan_q <= ((CHN_W'(chan_q) + CHN_W'(1)) >= chans_eff) ?
								'0 : chan_q + 1'b1;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			y_q   <= s_tdata[2*SMP_W-1:SMP_W];
			acc_q <= '0;
			if (pos_q == '0) begin
				u0_q <= in_u;
			end
		end else if (prod_vld_s1) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
		prod_s1 <= $signed(PROD_W'(cell_u[0])) * $signed(PROD_W'(cell_g[0]));
		if (state_q == S_PREP) begin
			num_neg_q <= num[ACC_W-1];
			dz_q      <= (u0_q == '0);
		end
		if (finish) begin
			m_tdata <= {{(48-COEF_W-IDX_W-CH_W){1'b0}}, chan_q, pos_q, g_res};
			m_tuser <= {dz_q, sat_res};
			m_tlast <= last_res;
		end
	end
endmodule
